### rtl/core/latching_relay_pulse_sequencer_defines.svh
// Assertion macros for the latching relay pulse sequencer checker.
// Depends on nothing; the asserting file supplies clk_i and rst_ni in scope.
`ifndef LATCHING_RELAY_PULSE_SEQUENCER_DEFINES_SVH
`define LATCHING_RELAY_PULSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet in reset
`define LRPS_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("lrps: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, quiet in reset
`define LRPS_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("lrps: next-cycle check failed");

`endif

### rtl/core/lrps_pkg.sv
// Shared types and constants for the latching relay pulse sequencer.
// Used by lrps_cfg, lrps_step and the top level; depends on nothing.
package lrps_pkg;

  localparam int unsigned CntW       = 4;
  localparam logic [CntW-1:0] PulseTicks = 4'd15;

  // Pending pulse bits
  localparam logic [3:0] PendR1 = 4'b0001;
  localparam logic [3:0] PendL1 = 4'b0010;
  localparam logic [3:0] PendR2 = 4'b0100;
  localparam logic [3:0] PendL2 = 4'b1000;

  // Pin level bits: relay levels, then coil lines one to four
  localparam logic [5:0] PinRel1  = 6'b000001;
  localparam logic [5:0] PinRel2  = 6'b000010;
  localparam logic [5:0] PinC1    = 6'b000100;
  localparam logic [5:0] PinC2    = 6'b001000;
  localparam logic [5:0] PinC3    = 6'b010000;
  localparam logic [5:0] PinC4    = 6'b100000;
  localparam logic [5:0] PinCoils = 6'b111100;

  // Register word indexes on the configuration port
  localparam logic RegStartup = 1'b0;

  typedef struct packed {
    logic            started;
    logic [1:0]      applied;
    logic [3:0]      pending;
    logic [CntW-1:0] countdown;
    logic [5:0]      pins;
  } lrps_state_t;

  typedef struct packed {
    logic [1:0] store_value;
    logic       store_valid;
    logic       coil_line4;
    logic       coil_line3;
    logic       coil_line2;
    logic       coil_line1;
    logic       relay2_level;
    logic       relay1_level;
  } lrps_result_t;

endpackage

### rtl/core/lrps_cfg.sv
// APB-style configuration register bank holding the startup request.
// Depends on lrps_pkg for the register index.
module lrps_cfg
  import lrps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  startup_o
);

  logic [1:0] startup_q;
  logic [1:0] startup_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegStartup);

  // Take a write in the access cycle
  always_comb begin
    startup_d = startup_q;
    if (wr_en) begin
      startup_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_q <= 2'b00;
    end else begin
      startup_q <= startup_d;
    end
  end

  // Read back; addresses beyond the bank read as zero
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegStartup) begin
      prdata = {30'd0, startup_q};
    end
  end

  assign startup_o = startup_q;

endmodule

### rtl/core/lrps_step.sv
// Single-tick update of the relay pulse sequencer: next state and result.
// Pure logic; depends on lrps_pkg for state and result types.
module lrps_step
  import lrps_pkg::*;
(
  input  lrps_state_t  state_i,
  input  logic [1:0]   req_i,
  input  logic [1:0]   startup_i,
  output lrps_state_t  state_o,
  output lrps_result_t result_o
);

  logic [1:0]      app;
  logic [1:0]      change;
  logic [3:0]      pend;
  logic [3:0]      serve;
  logic [CntW-1:0] cd;
  logic [5:0]      pins;
  logic            sv;
  logic [1:0]      sval;

  always_comb begin
    // Seed the applied positions from the startup request on the first tick
    app    = state_i.started ? state_i.applied : {1'b0, (startup_i == 2'b00)};
    pend   = state_i.pending;
    cd     = state_i.countdown;
    pins   = state_i.pins;
    sv     = 1'b0;
    sval   = 2'b00;
    change = req_i ^ app;

    // Queue pulses for a changed request when idle
    if (pend == 4'd0 && cd == '0 && change != 2'b00) begin
      if (change[0]) pend = pend | (req_i[0] ? PendR1 : PendL1);
      if (change[1]) pend = pend | (req_i[1] ? PendR2 : PendL2);
      cd   = PulseTicks;
      app  = req_i;
      sv   = 1'b1;
      sval = req_i;
    end

    if (pend == 4'd0) begin
      pins = pins & ~PinCoils;
    end

    // Serve the first pending pulse in fixed order
    serve = 4'd0;
    if ((pend & PendR1) != 4'd0) begin
      pins  = pins | PinRel1 | PinC2 | PinC3;
      serve = PendR1;
    end else if ((pend & PendL1) != 4'd0) begin
      pins  = (pins & ~PinRel1) | PinC1 | PinC4;
      serve = PendL1;
    end else if ((pend & PendR2) != 4'd0) begin
      pins  = pins | PinRel2 | PinC3 | PinC4;
      serve = PendR2;
    end else if ((pend & PendL2) != 4'd0) begin
      pins  = (pins & ~PinRel2) | PinC1 | PinC2;
      serve = PendL2;
    end

    // Finish the served pulse once its countdown has run out
    if (serve != 4'd0 && cd == '0) begin
      pend = pend & ~serve;
      cd   = PulseTicks;
      pins = pins & ~PinCoils;
    end

    // Advance the countdown, or drop whatever is left
    if (cd == '0) begin
      pend = 4'd0;
    end else begin
      cd = cd - 1'b1;
    end

    state_o.started   = 1'b1;
    state_o.applied   = app;
    state_o.pending   = pend;
    state_o.countdown = cd;
    state_o.pins      = pins;

    result_o.relay1_level = pins[0];
    result_o.relay2_level = pins[1];
    result_o.coil_line1   = pins[2];
    result_o.coil_line2   = pins[3];
    result_o.coil_line3   = pins[4];
    result_o.coil_line4   = pins[5];
    result_o.store_valid  = sv;
    result_o.store_value  = sval;
  end

endmodule

### rtl/core/latching_relay_pulse_sequencer.sv
// Top level of the latching relay pulse sequencer.
// Depends on lrps_pkg, lrps_cfg and lrps_step.
//
//   port group    | dir | role
//   s_axis_*      | in  | tick transactions, tdata[1:0] = request_bits
//   m_axis_*      | out | one result transaction per tick
//   p* (APB)      | in  | register 0 at byte 0: startup_request
//
// Each tick passes through the input register and then the result
// register; one tick per cycle is sustained while m_axis does not stall,
// since the state update in lrps_step is combinational.
// rst_ni clears the state, the startup register and both valid flags.
// A stall on m_axis holds the result; the input register still takes one
// more tick, then s_axis_tready drops until the result is taken.
module latching_relay_pulse_sequencer
  import lrps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [1:0] request_bits, [7:2] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] relay1_level, [1] relay2_level, [5:2] coil_line1..4,
  // [6] store_valid, [8:7] store_value, [15:9] zero
  output logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic         in_valid_q, in_valid_d;
  logic [1:0]   in_req_q, in_req_d;
  logic         out_valid_q, out_valid_d;
  lrps_result_t out_q, out_d;
  lrps_state_t  state_q, state_d;
  lrps_state_t  step_state;
  lrps_result_t step_result;
  logic [1:0]   startup;
  logic         out_free;
  logic         fire;

  lrps_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .startup_o (startup)
  );

  lrps_step u_step (
    .state_i   (state_q),
    .req_i     (in_req_q),
    .startup_i (startup),
    .state_o   (step_state),
    .result_o  (step_result)
  );

  // Handshake: the result register frees when empty or being taken
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_comb begin
    in_valid_d  = in_valid_q;
    in_req_d    = in_req_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    state_d     = state_q;
    // Hand the registered tick to the step logic
    if (fire) begin
      state_d     = step_state;
      out_d       = step_result;
      out_valid_d = 1'b1;
      in_valid_d  = 1'b0;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
    // Capture a new tick
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_req_d   = s_axis_tdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_req_q <= in_req_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

endmodule

### rtl/core/lrps_checker.sv
// Port-level checker for the latching relay pulse sequencer, with its bind.
// Depends on latching_relay_pulse_sequencer_defines.svh.
`include "latching_relay_pulse_sequencer_defines.svh"

module lrps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        pready
);

  logic [3:0] coils;

  assign coils = m_axis_tdata[5:2];

  // Coil lines are released together or drive exactly one pair
  `LRPS_ASSERT_NOW(a_coil_pair, m_axis_tvalid, ($countones(coils) == 0 || $countones(coils) == 2))

  // A freshly stored request always starts a pulse
  `LRPS_ASSERT_NOW(a_store_drives, m_axis_tvalid && m_axis_tdata[6], (coils != 4'd0))

  // No stored value without the store flag
  `LRPS_ASSERT_NOW(a_store_zero, m_axis_tvalid && !m_axis_tdata[6], (m_axis_tdata[8:7] == 2'd0))

  // Hold a stalled result
  `LRPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, (m_axis_tvalid && $stable(m_axis_tdata)))

  // Config port never waits
  `LRPS_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind latching_relay_pulse_sequencer lrps_checker u_lrps_checker (.*);
